// ===== design/mi3_pkg.sv =====
// Shared constants, cofactor index tables and saturation for the 3x3 matrix inverter.
// Used by design/matrix3x3_inverse.sv; depends on nothing.
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NELEM     = 9;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int LW        = PW + 1;
    localparam int TW        = 3 * DW + 1;
    localparam int MAGW      = TW - 1;
    localparam int NW        = PW + 2 * FRAC_BITS;
    localparam int NHW       = NW - DW;
    localparam int CW        = DW - 1;
    localparam int THRW      = CW + 2 * FRAC_BITS;
    localparam int DIV_STEPS = DW;
    localparam int FRONT     = 6;
    localparam int NSTAGE    = FRONT + DIV_STEPS + 1;
    localparam int IN_W      = NELEM * DW;
    localparam int OUT_W     = (NELEM + 1) * DW;

    typedef logic signed [DW-1:0]  fix_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [LW-1:0]  lprod_t;
    typedef logic signed [TW-1:0]  wide_t;
    typedef logic [MAGW-1:0]       mag_t;
    typedef logic [3:0]            idx_t;

    // cofactor k = a[P]*a[Q] - a[R]*a[S]
    localparam idx_t IDX_P [NELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_t IDX_Q [NELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam idx_t IDX_R [NELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_t IDX_S [NELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    function automatic logic [DW-1:0] sat32(input logic neg, input logic big,
                                            input logic [DW-1:0] m);
        logic [DW-1:0] r;
        if (neg) begin
            if (big || (m > {1'b1, {(DW-1){1'b0}}})) begin
                r = {1'b1, {(DW-1){1'b0}}};
            end else begin
                r = ~m + 1'b1;
            end
        end else begin
            if (big || m[DW-1]) begin
                r = {1'b0, {(DW-1){1'b1}}};
            end else begin
                r = m;
            end
        end
        return r;
    endfunction

endpackage

// ===== design/matrix3x3_inverse.sv =====
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// Depends on mi3_pkg (constants, index tables, saturation).
//
// Usage:
//   s_ channel: one matrix per transfer, nine signed Q16.16 entries.
//   m_ channel: nine inverse entries, the determinant and a singular flag.
//   cfg_wr_en/cfg_wr_data: singular threshold on |det|, write while idle.
// Throughput: one matrix per cycle while s_tready is high.
// Pipeline from input transfer to m_tvalid: six stages of
//   products, cofactors and determinant, one divider setup stage, 32
//   restoring divider stages (one quotient bit each, nine lanes), and the
//   output register.
// Singular matrices (|det| <= threshold) come back unchanged with the flag.
// Reset clears all valid bits and the threshold; nothing is in flight after.
// Receiver stall: the output register plus a one-entry skid buffer; the
//   pipeline freezes only once the skid is full, and s_tready drops then.
module matrix3x3_inverse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mi3_pkg::CW-1:0]      cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // a00 a01 a02 a10 a11 a12 a20 a21 a22, 32 bits each
    input  logic [mi3_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // r00 r01 r02 r10 r11 r12 r20 r21 r22 determinant, 32 bits each
    output logic [mi3_pkg::OUT_W-1:0]   m_tdata,
    // singular
    output logic [0:0]                  m_tuser
);

    localparam int N  = mi3_pkg::NELEM;
    localparam int DW = mi3_pkg::DW;
    localparam int F2 = 2 * mi3_pkg::FRAC_BITS;
    localparam int DS = mi3_pkg::DIV_STEPS;

    logic [mi3_pkg::CW-1:0] thr_reg;
    logic [mi3_pkg::NSTAGE-1:0] v_reg;
    logic ce;

    mi3_pkg::fix_t   s_a   [N];
    mi3_pkg::fix_t   a1_reg [N], a2_reg [N], a3_reg [N], a4_reg [N], a5_reg [N], a6_reg [N];
    mi3_pkg::prod_t  pa_reg [N], pb_reg [N];
    mi3_pkg::prod_t  c2_reg [N], c3_reg [N], c4_reg [N], c5_reg [N];
    mi3_pkg::prod_t  ph_reg [3];
    mi3_pkg::lprod_t pl_reg [3];
    mi3_pkg::wide_t  t_reg  [3];
    mi3_pkg::wide_t  det_reg;
    mi3_pkg::mag_t   det_mag;

    mi3_pkg::mag_t           dmag6_reg;
    logic                    sing6_reg;
    logic [DW-1:0]           dout6_reg;
    logic [mi3_pkg::NW-1:0]  num6_reg [N];
    logic [N-1:0]            neg6_reg;

    mi3_pkg::mag_t  rem_reg  [DS+1][N];
    logic [DW-1:0]  nlo_reg  [DS+1][N];
    logic [DW-1:0]  quo_reg  [DS+1][N];
    logic [DW-1:0]  ad_reg   [DS+1][N];
    logic [N-1:0]   ovf_reg  [DS+1];
    logic [N-1:0]   negd_reg [DS+1];
    mi3_pkg::mag_t  dmag_reg [DS+1];
    logic [DW-1:0]  dout_reg [DS+1];
    logic           sing_reg [DS+1];

    logic [mi3_pkg::OUT_W-1:0] tail_data;
    logic [mi3_pkg::OUT_W-1:0] out_data_reg, skid_data_reg;
    logic out_user_reg, skid_user_reg, out_valid_reg, skid_full_reg;
    logic tail_v;

    assign ce       = !skid_full_reg;
    assign s_tready = ce;
    assign tail_v   = v_reg[mi3_pkg::NSTAGE-1];
    assign det_mag  = det_reg[mi3_pkg::TW-1] ? mi3_pkg::MAGW'(-det_reg)
                                             : mi3_pkg::MAGW'(det_reg);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            s_a[i] = $signed(s_tdata[DW*i +: DW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[mi3_pkg::NSTAGE-2:0], s_tvalid};
        end
    end

    // front: products, cofactors, determinant, magnitude and threshold
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < N; i++) begin
                pa_reg[i] <= mi3_pkg::PW'(s_a[mi3_pkg::IDX_P[i]])
                           * mi3_pkg::PW'(s_a[mi3_pkg::IDX_Q[i]]);
                pb_reg[i] <= mi3_pkg::PW'(s_a[mi3_pkg::IDX_R[i]])
                           * mi3_pkg::PW'(s_a[mi3_pkg::IDX_S[i]]);
                a1_reg[i] <= s_a[i];
                c2_reg[i] <= pa_reg[i] - pb_reg[i];
                a2_reg[i] <= a1_reg[i];
                c3_reg[i] <= c2_reg[i];
                a3_reg[i] <= a2_reg[i];
                c4_reg[i] <= c3_reg[i];
                a4_reg[i] <= a3_reg[i];
                c5_reg[i] <= c4_reg[i];
                a5_reg[i] <= a4_reg[i];
                a6_reg[i] <= a5_reg[i];
                num6_reg[i] <= {(c5_reg[i][mi3_pkg::PW-1] ? -c5_reg[i] : c5_reg[i]),
                                {F2{1'b0}}};
                neg6_reg[i] <= c5_reg[i][mi3_pkg::PW-1] ^ det_reg[mi3_pkg::TW-1];
            end
            for (int k = 0; k < 3; k++) begin
                ph_reg[k] <= mi3_pkg::PW'($signed(c2_reg[3*k][mi3_pkg::PW-1:DW]))
                           * mi3_pkg::PW'(a2_reg[k]);
                pl_reg[k] <= mi3_pkg::LW'($signed({1'b0, c2_reg[3*k][DW-1:0]}))
                           * mi3_pkg::LW'(a2_reg[k]);
                t_reg[k]  <= (mi3_pkg::TW'(ph_reg[k]) <<< DW) + mi3_pkg::TW'(pl_reg[k]);
            end
            det_reg   <= t_reg[0] + t_reg[1] + t_reg[2];
            dmag6_reg <= det_mag;
            sing6_reg <= det_mag <= mi3_pkg::MAGW'({thr_reg, {F2{1'b0}}});
        end
    end

    // determinant output, truncated toward zero and saturated
    always_ff @(posedge aclk) begin
        if (ce) begin
            dout6_reg <= mi3_pkg::sat32(det_reg[mi3_pkg::TW-1],
                                        |det_mag[mi3_pkg::MAGW-1:DW+F2],
                                        det_mag[DW+F2-1:F2]);
        end
    end

    // divider setup and restoring steps, one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < N; i++) begin
                rem_reg[0][i] <= mi3_pkg::MAGW'(num6_reg[i][mi3_pkg::NW-1:DW]);
                ovf_reg[0][i] <= mi3_pkg::MAGW'(num6_reg[i][mi3_pkg::NW-1:DW]) >= dmag6_reg;
                nlo_reg[0][i] <= num6_reg[i][DW-1:0];
                quo_reg[0][i] <= '0;
                ad_reg[0][i]  <= a6_reg[i];
            end
            negd_reg[0] <= neg6_reg;
            dmag_reg[0] <= dmag6_reg;
            sing_reg[0] <= sing6_reg;
            dout_reg[0] <= dout6_reg;
            for (int j = 1; j <= DS; j++) begin
                for (int i = 0; i < N; i++) begin
                    logic [mi3_pkg::MAGW:0] tr;
                    logic ge;
                    tr = {rem_reg[j-1][i], nlo_reg[j-1][i][DS-j]};
                    ge = tr >= {1'b0, dmag_reg[j-1]};
                    rem_reg[j][i] <= ge ? mi3_pkg::MAGW'(tr - {1'b0, dmag_reg[j-1]})
                                        : mi3_pkg::MAGW'(tr);
                    quo_reg[j][i] <= {quo_reg[j-1][i][DW-2:0], ge};
                    nlo_reg[j][i] <= nlo_reg[j-1][i];
                    ad_reg[j][i]  <= ad_reg[j-1][i];
                end
                ovf_reg[j]  <= ovf_reg[j-1];
                negd_reg[j] <= negd_reg[j-1];
                dmag_reg[j] <= dmag_reg[j-1];
                sing_reg[j] <= sing_reg[j-1];
                dout_reg[j] <= dout_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            tail_data[DW*i +: DW] = sing_reg[DS] ? ad_reg[DS][i]
                : mi3_pkg::sat32(negd_reg[DS][i], ovf_reg[DS][i], quo_reg[DS][i]);
        end
        tail_data[DW*N +: DW] = dout_reg[DS];
    end

    // output register and skid buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            out_valid_reg <= skid_full_reg || tail_v;
            skid_full_reg <= 1'b0;
        end else if (tail_v && ce) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_full_reg ? skid_data_reg : tail_data;
            out_user_reg <= skid_full_reg ? skid_user_reg : sing_reg[DS];
        end else if (ce) begin
            skid_data_reg <= tail_data;
            skid_user_reg <= sing_reg[DS];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

    a_skid_has_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds data while output is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_v && !sing_reg[DS] && !ovf_reg[DS][0]) |-> (rem_reg[DS][0] < dmag_reg[DS]))
        else $error("divider remainder not below divisor");

    a_zero_det_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[mi3_pkg::FRONT-1] && dmag6_reg == '0) |-> sing6_reg)
        else $error("zero determinant not flagged singular");

endmodule
